FILE: hw/rtl/lidar_packet_parser_defines.svh
// Assertion macros shared by the lidar packet parser RTL.
`ifndef LIDAR_PACKET_PARSER_DEFINES_SVH
`define LIDAR_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lpp_pkg.sv
// Types and constants of the lidar packet parser.
`default_nettype none

package lpp_pkg;

  localparam int PACKET_BYTES = 22;
  localparam int POS_W        = 5;
  localparam int ACC_W        = 26;
  localparam int CSUM_W       = 15;
  localparam int CNT_W        = 10;
  localparam int READINGS     = 4;
  localparam int RD_W         = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  typedef logic [7:0]         byte_t;
  typedef logic [8:0]         angle_t;
  typedef logic [13:0]        dist_t;
  typedef logic [15:0]        speed_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [RD_W-1:0]    rd_idx_t;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BASE = 1'b1;

  localparam byte_t   START_BYTE_RST = 8'd250;
  localparam byte_t   INDEX_BASE_RST = 8'd160;
  localparam byte_t   IDX_SPAN       = 8'd90;
  localparam cnt_t    CNT_MAX        = 10'd1023;
  localparam pos_t    LAST_POS       = POS_W'(PACKET_BYTES - 1);
  localparam pos_t    CSUM_POS       = POS_W'(PACKET_BYTES - 2);
  localparam rd_idx_t LAST_READ      = RD_W'(READINGS - 1);

endpackage

`default_nettype wire

FILE: hw/rtl/lpp_in_if.sv
// Byte stream channel into the lidar packet parser.
`default_nettype none

interface lpp_in_if;
  import lpp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lpp_out_if.sv
// Reading channel out of the lidar packet parser.
`default_nettype none

interface lpp_out_if;
  import lpp_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle;
  dist_t  distance;
  logic   invalid;
  logic   warning;
  speed_t speed;
  logic   checksum_ok;
  logic   index_ok;
  logic   scan_start;
  cnt_t   good_count;
  cnt_t   bad_count;
  logic   last;

  modport source (
    output valid, output angle, output distance, output invalid, output warning,
    output speed, output checksum_ok, output index_ok, output scan_start,
    output good_count, output bad_count, output last, input ready
  );
  modport sink (
    input valid, input angle, input distance, input invalid, input warning,
    input speed, input checksum_ok, input index_ok, input scan_start,
    input good_count, input bad_count, input last, output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/lidar_packet_parser.sv
// Lidar packet parser top level: framing, checksum and reading emission.
// Takes one byte per cycle; ready drops only on a packet's final byte while any
// of the four readings of the previous packet is still queued in the hold registers.
// The first reading passes through pkt_done_r, the hold registers and the output
// register, then one reading per cycle follows as the output register drains.
// Synchronous active-low reset: start byte 250, index base 160, aligned, counts 0.
`default_nettype none
`include "lidar_packet_parser_defines.svh"

module lidar_packet_parser (
  input wire logic                           clk,
  input wire logic                           rst_n,
  lpp_in_if.sink                             in_ch,
  lpp_out_if.source                          out_ch,
  input wire logic                           cfg_we,
  input wire logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input wire logic [lpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpp_pkg::*;

  localparam logic [1:0] MODE_ALIGNED  = 2'd0;
  localparam logic [1:0] MODE_HUNTING  = 2'd1;
  localparam logic [1:0] MODE_SKIPPING = 2'd2;

  function automatic cnt_t sat_add(cnt_t a, logic [2:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W + 1)'(b);
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // configuration
  byte_t start_byte_r, index_base_r;

  // framing
  logic [1:0] frame_mode_r, frame_mode_nxt;
  pos_t       pos_r, pos_nxt;
  pos_t       skip_left_r, skip_left_nxt, skip_dec;
  acc_t       acc_r, acc_nxt, acc_base;
  byte_t      low_hold_r, low_hold_nxt;
  byte_t      store_r [PACKET_BYTES];
  logic       store_we;
  logic       pkt_done_r, pkt_done_nxt;
  logic       in_fire, aligned;

  // packet evaluation
  logic [CSUM_W:0] calc_sum;
  logic [15:0]     given_sum;
  logic            ck_ok, idx_ok, scan;
  byte_t           offset;

  // reading hold
  logic       hold_valid_r;
  rd_idx_t    rd_idx_r;
  speed_t     hold_speed_r;
  logic       hold_ck_ok_r, hold_idx_ok_r, hold_scan_r;
  logic [6:0] hold_base_r;
  byte_t      hold_lo_r [READINGS];
  byte_t      hold_hi_r [READINGS];
  byte_t      rd_lo, rd_hi;
  logic       rd_inv;
  dist_t      rd_dist;
  logic       emit;
  cnt_t       good_r, good_nxt, bad_r, bad_nxt, bad_tmp;

  // output register
  logic   out_valid_r;
  angle_t out_angle_r;
  dist_t  out_distance_r;
  logic   out_invalid_r, out_warning_r, out_ck_ok_r, out_idx_ok_r, out_scan_r, out_last_r;
  speed_t out_speed_r;
  cnt_t   out_good_r, out_bad_r;

  assign aligned     = (frame_mode_r != MODE_HUNTING) && (frame_mode_r != MODE_SKIPPING);
  assign in_ch.ready = !(aligned && (pos_r == LAST_POS) && (hold_valid_r || pkt_done_r));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign skip_dec    = (skip_left_r != '0) ? skip_left_r - 1'b1 : skip_left_r;
  assign acc_base    = (pos_r == '0) ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      index_base_r <= INDEX_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START_BYTE: start_byte_r <= cfg_wdata;
        REG_INDEX_BASE: index_base_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    frame_mode_nxt = frame_mode_r;
    pos_nxt        = pos_r;
    skip_left_nxt  = skip_left_r;
    acc_nxt        = acc_r;
    low_hold_nxt   = low_hold_r;
    store_we       = 1'b0;
    pkt_done_nxt   = 1'b0;
    if (in_fire) begin
      unique case (frame_mode_r)
        MODE_HUNTING: begin
          if (in_ch.rx_byte == start_byte_r) begin
            frame_mode_nxt = MODE_SKIPPING;
            skip_left_nxt  = LAST_POS;
          end
        end
        MODE_SKIPPING: begin
          skip_left_nxt = skip_dec;
          if (skip_dec == '0) begin
            frame_mode_nxt = MODE_ALIGNED;
            pos_nxt        = '0;
            acc_nxt        = '0;
          end
        end
        default: begin
          frame_mode_nxt = MODE_ALIGNED;
          store_we       = 1'b1;
          acc_nxt        = acc_base;
          if (pos_r < CSUM_POS) begin
            if (!pos_r[0]) begin
              low_hold_nxt = in_ch.rx_byte;
            end else begin
              acc_nxt = {acc_base[ACC_W-2:0], 1'b0} + ACC_W'({in_ch.rx_byte, low_hold_r});
            end
          end
          if (pos_r == LAST_POS) begin
            pos_nxt = '0;
            // byte 0 of this packet is already in the store
            if (store_r[0] != start_byte_r) begin
              frame_mode_nxt = MODE_HUNTING;
            end else begin
              pkt_done_nxt = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r <= MODE_ALIGNED;
      pos_r        <= '0;
      skip_left_r  <= '0;
      pkt_done_r   <= 1'b0;
    end else begin
      frame_mode_r <= frame_mode_nxt;
      pos_r        <= pos_nxt;
      skip_left_r  <= skip_left_nxt;
      pkt_done_r   <= pkt_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    low_hold_r <= low_hold_nxt;
    if (store_we) begin
      store_r[pos_r] <= in_ch.rx_byte;
    end
  end

  // Evaluated in the cycle after the final byte; a new byte 0 may land in the
  // store and clear the accumulator only at the end of that cycle.
  assign calc_sum  = {1'b0, acc_r[CSUM_W-1:0]} + (CSUM_W + 1)'(acc_r[ACC_W-1:CSUM_W]);
  assign given_sum = {store_r[21], store_r[20]};
  assign ck_ok     = given_sum == {1'b0, calc_sum[CSUM_W-1:0]};
  assign offset    = store_r[1] - index_base_r;
  assign idx_ok    = offset < IDX_SPAN;
  assign scan      = idx_ok && (offset == '0);

  assign emit    = hold_valid_r && (!out_valid_r || out_ch.ready);
  assign rd_lo   = hold_lo_r[rd_idx_r];
  assign rd_hi   = hold_hi_r[rd_idx_r];
  assign rd_inv  = rd_hi[7] || !hold_idx_ok_r;
  assign rd_dist = rd_inv ? '0 : {rd_hi[5:0], rd_lo};

  always_comb begin
    good_nxt = good_r;
    bad_nxt  = bad_r;
    bad_tmp  = ck_ok ? bad_r : sat_add(bad_r, 3'd4);
    if (pkt_done_r) begin
      good_nxt = scan ? '0 : good_r;
      bad_nxt  = scan ? '0 : bad_tmp;
    end else if (emit) begin
      if (rd_inv) begin
        bad_nxt = sat_add(bad_r, 3'd1);
      end else begin
        good_nxt = sat_add(good_r, 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      rd_idx_r     <= '0;
      good_r       <= '0;
      bad_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      good_r <= good_nxt;
      bad_r  <= bad_nxt;
      if (pkt_done_r) begin
        hold_valid_r <= 1'b1;
        rd_idx_r     <= '0;
      end else if (emit) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        if (rd_idx_r == LAST_READ) begin
          hold_valid_r <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done_r) begin
      hold_speed_r  <= {store_r[3], store_r[2]};
      hold_ck_ok_r  <= ck_ok;
      hold_idx_ok_r <= idx_ok;
      hold_scan_r   <= scan;
      hold_base_r   <= idx_ok ? offset[6:0] : '0;
      for (int i = 0; i < READINGS; i++) begin
        hold_lo_r[i] <= store_r[4 + 4 * i];
        hold_hi_r[i] <= store_r[5 + 4 * i];
      end
    end
    if (emit) begin
      // a bad index reports angle 0 on all four readings
      out_angle_r    <= hold_idx_ok_r ? {hold_base_r, rd_idx_r} : '0;
      out_distance_r <= rd_dist;
      out_invalid_r  <= rd_inv;
      out_warning_r  <= rd_hi[6];
      out_speed_r    <= hold_speed_r;
      out_ck_ok_r    <= hold_ck_ok_r;
      out_idx_ok_r   <= hold_idx_ok_r;
      out_scan_r     <= hold_scan_r;
      out_good_r     <= good_nxt;
      out_bad_r      <= bad_nxt;
      out_last_r     <= rd_idx_r == LAST_READ;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.angle       = out_angle_r;
  assign out_ch.distance    = out_distance_r;
  assign out_ch.invalid     = out_invalid_r;
  assign out_ch.warning     = out_warning_r;
  assign out_ch.speed       = out_speed_r;
  assign out_ch.checksum_ok = out_ck_ok_r;
  assign out_ch.index_ok    = out_idx_ok_r;
  assign out_ch.scan_start  = out_scan_r;
  assign out_ch.good_count  = out_good_r;
  assign out_ch.bad_count   = out_bad_r;
  assign out_ch.last        = out_last_r;

  `LPP_ASSERT_SAME(a_hold_free, pkt_done_r, !hold_valid_r, "packet done while readings pending")
  `LPP_ASSERT_NEXT(a_hold_load, pkt_done_r, hold_valid_r && (rd_idx_r == '0), "hold not loaded")
  `LPP_ASSERT_SAME(a_skip_live, frame_mode_r == MODE_SKIPPING, skip_left_r != '0, "skip count empty")
  `LPP_ASSERT_NEXT(a_hunt_quiet, in_fire && (frame_mode_r == MODE_HUNTING), !pkt_done_r, "emit while hunting")

endmodule

`default_nettype wire

FILE: bench/lidar_packet_parser_tb.sv
// Self-checking testbench for the lidar packet parser: framing, checksum, counters, resync.
`timescale 1ns / 1ps

module lidar_packet_parser_tb;
  import lpp_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int INDEX_SPAN   = 90;
  localparam int CNT_CAP      = 1023;

  typedef logic [PACKET_BYTES*8-1:0] pkt_t;
  typedef enum logic [1:0] {FRAME_SYNC, FRAME_HUNT, FRAME_SKIP} frame_e;

  typedef struct packed {
    angle_t angle;
    dist_t  distance;
    logic   invalid;
    logic   warning;
    speed_t speed;
    logic   checksum_ok;
    logic   index_ok;
    logic   scan_start;
    cnt_t   good_count;
    cnt_t   bad_count;
    logic   last;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lpp_in_if  in_ch ();
  lpp_out_if out_ch ();

  lidar_packet_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stimulus side
  byte_t byte_q[$];
  int    bytes_queued = 0;
  int    in_idle_pct = 0;
  int    out_stall_pct = 0;
  byte_t set_start = START_BYTE_RST;
  byte_t set_base = INDEX_BASE_RST;
  logic  in_taken;

  // predictor state
  frame_e   frame_st;
  int       pkt_pos;
  int       skip_cnt;
  pkt_t     pkt_buf;
  int       good_total;
  int       bad_total;
  byte_t    start_reg;
  byte_t    base_reg;
  reading_t exp_readings[$];

  // bookkeeping
  int bytes_done = 0;
  int readings_checked = 0;
  int packets_framed = 0;
  int resyncs = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  function automatic byte_t byte_at(pkt_t p, int n);
    return p[n*8 +: 8];
  endfunction

  // shift-and-add over the ten little-endian words in bytes 0..19, folded to 15 bits
  function automatic logic [14:0] fold_checksum(pkt_t p);
    logic [25:0] acc;
    acc = '0;
    for (int w = 0; w < 10; w++)
      acc = (acc << 1) + {byte_at(p, 2*w + 1), byte_at(p, 2*w)};
    return 15'(((acc & 26'h7FFF) + (acc >> 15)) & 26'h7FFF);
  endfunction

  function automatic int sat_cnt(int v);
    return (v > CNT_CAP) ? CNT_CAP : v;
  endfunction

  task automatic reset_parser();
    frame_st   = FRAME_SYNC;
    pkt_pos    = 0;
    skip_cnt   = 0;
    pkt_buf    = '0;
    good_total = 0;
    bad_total  = 0;
    start_reg  = START_BYTE_RST;
    base_reg   = INDEX_BASE_RST;
  endtask

  task automatic emit_readings();
    logic [15:0] given;
    logic        ck_ok;
    logic        idx_ok;
    logic        scan;
    byte_t       offset;
    byte_t       lo;
    byte_t       hi;
    reading_t    r;
    given  = {byte_at(pkt_buf, 21), byte_at(pkt_buf, 20)};
    ck_ok  = ({1'b0, fold_checksum(pkt_buf)} == given);
    offset = byte_at(pkt_buf, 1) - base_reg;
    idx_ok = (int'(offset) < INDEX_SPAN);
    scan   = idx_ok && (offset == 8'd0);
    packets_framed++;
    if (!ck_ok)
      bad_total = sat_cnt(bad_total + 4);
    // new revolution: totals restart after the checksum penalty
    if (scan) begin
      good_total = 0;
      bad_total  = 0;
    end
    for (int i = 0; i < READINGS; i++) begin
      lo = byte_at(pkt_buf, 4 + 4*i);
      hi = byte_at(pkt_buf, 5 + 4*i);
      r.invalid  = hi[7] | ~idx_ok;
      r.warning  = hi[6];
      r.distance = r.invalid ? '0 : {hi[5:0], lo};
      r.angle    = idx_ok ? angle_t'(int'(offset) * 4 + i) : '0;
      if (r.invalid)
        bad_total = sat_cnt(bad_total + 1);
      else
        good_total = sat_cnt(good_total + 1);
      r.speed       = {byte_at(pkt_buf, 3), byte_at(pkt_buf, 2)};
      r.checksum_ok = ck_ok;
      r.index_ok    = idx_ok;
      r.scan_start  = scan;
      r.good_count  = cnt_t'(good_total);
      r.bad_count   = cnt_t'(bad_total);
      r.last        = (i == READINGS - 1);
      exp_readings.push_back(r);
    end
  endtask

  task automatic parse_byte(input byte_t b);
    case (frame_st)
      FRAME_HUNT: begin
        if (b == start_reg) begin
          frame_st = FRAME_SKIP;
          skip_cnt = PACKET_BYTES - 1;
        end
      end
      FRAME_SKIP: begin
        if (skip_cnt > 0)
          skip_cnt--;
        if (skip_cnt == 0) begin
          frame_st = FRAME_SYNC;
          pkt_pos  = 0;
        end
      end
      default: begin
        frame_st = FRAME_SYNC;
        pkt_buf[pkt_pos*8 +: 8] = b;
        pkt_pos++;
        if (pkt_pos == PACKET_BYTES) begin
          pkt_pos = 0;
          if (byte_at(pkt_buf, 0) != start_reg) begin
            frame_st = FRAME_HUNT;
            resyncs++;
          end else begin
            emit_readings();
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic compare_reading(input reading_t want, input reading_t got);
    check_field("angle", want.angle, got.angle);
    check_field("distance", want.distance, got.distance);
    check_field("invalid", want.invalid, got.invalid);
    check_field("warning", want.warning, got.warning);
    check_field("speed", want.speed, got.speed);
    check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
    check_field("index_ok", want.index_ok, got.index_ok);
    check_field("scan_start", want.scan_start, got.scan_start);
    check_field("good_count", want.good_count, got.good_count);
    check_field("bad_count", want.bad_count, got.bad_count);
    check_field("last", want.last, got.last);
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic push_byte(input byte_t b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  function automatic byte_t other_byte();
    byte_t b;
    do b = byte_t'($urandom); while (b == set_start);
    return b;
  endfunction

  // high byte bit 7 (invalid) set about one time in five
  function automatic logic [15:0] rand_reading();
    logic [15:0] r;
    r = 16'($urandom);
    r[15] = ($urandom_range(4) == 0);
    return r;
  endfunction

  function automatic byte_t good_index();
    return byte_t'(set_base + $urandom_range(INDEX_SPAN - 1));
  endfunction

  task automatic queue_packet(input byte_t first, input byte_t idx, input speed_t spd,
                              input logic [63:0] rd, input bit ck_good, input int keep);
    pkt_t        p;
    logic [15:0] ck_word;
    for (int n = 0; n < PACKET_BYTES; n++)
      p[n*8 +: 8] = byte_t'($urandom);
    p[7:0]   = first;
    p[15:8]  = idx;
    p[31:16] = spd;
    for (int i = 0; i < READINGS; i++)
      p[(4 + 4*i)*8 +: 16] = rd[i*16 +: 16];
    ck_word = {1'b0, fold_checksum(p)};
    if (!ck_good)
      ck_word ^= 16'($urandom_range(65535, 1));
    p[(PACKET_BYTES - 2)*8 +: 16] = ck_word;
    for (int n = 0; n < keep; n++)
      push_byte(p[n*8 +: 8]);
  endtask

  task automatic queue_random_packet();
    byte_t idx;
    if ($urandom_range(99) < 85)
      idx = good_index();
    else
      idx = byte_t'(set_base + INDEX_SPAN + $urandom_range(255 - INDEX_SPAN));
    queue_packet(set_start, idx, speed_t'($urandom),
                 {rand_reading(), rand_reading(), rand_reading(), rand_reading()},
                 $urandom_range(99) < 85, PACKET_BYTES);
  endtask

  // from hunting: a few stray bytes, the start byte, then the skipped remainder
  task automatic resync_from_hunt();
    repeat ($urandom_range(5)) push_byte(other_byte());
    push_byte(set_start);
    repeat (PACKET_BYTES - 1) push_byte(byte_t'($urandom));
  endtask

  task automatic wait_idle();
    while (bytes_done != bytes_queued || exp_readings.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_framing(input byte_t sb, input byte_t base);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_START_BYTE;
    cfg_wdata <= sb;
    @(negedge clk);
    cfg_idx   <= REG_INDEX_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_we    <= 1'b0;
    set_start = sb;
    set_base  = base;
  endtask

  // ---------------- driver, receiver, monitor ----------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= byte_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : monitor
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      reset_parser();
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        bytes_done++;
        parse_byte(in_ch.rx_byte);
      end
      // a write lands after any byte taken on the same edge
      if (cfg_we) begin
        if (cfg_idx == REG_START_BYTE)
          start_reg = cfg_wdata;
        else if (cfg_idx == REG_INDEX_BASE)
          base_reg = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.angle, out_ch.distance, out_ch.invalid, out_ch.warning, out_ch.speed,
               out_ch.checksum_ok, out_ch.index_ok, out_ch.scan_start, out_ch.good_count,
               out_ch.bad_count, out_ch.last};
        if (exp_readings.size() == 0) begin
          $error("reading with none expected: angle %0d distance %0d",
                 got.angle, got.distance);
          err_count++;
        end else begin
          want = exp_readings.pop_front();
          readings_checked++;
          compare_reading(want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lidar_packet_parser_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, revolution, last angle with bad checksum, resync, bad index
    set_framing(8'd250, 8'd160);
    queue_packet(8'd250, 8'd160, 16'hFFFF, {16'h7FFF, 16'h8123, 16'h3FFF, 16'h0000},
                 1'b1, PACKET_BYTES);
    queue_packet(8'd250, 8'd249, 16'h0000,
                 {rand_reading(), rand_reading(), rand_reading(), 16'hC0FF},
                 1'b0, PACKET_BYTES);
    queue_packet(8'd0, 8'd170, 16'hFF00, {4{16'h0202}}, 1'b1, PACKET_BYTES);
    resync_from_hunt();
    queue_packet(8'd250, 8'd159, 16'hAAAA, {4{16'h1555}}, 1'b1, PACKET_BYTES);
    wait_idle();

    // one random packet under each idling pattern and register setting
    set_framing(8'd0, 8'd255);
    in_idle_pct = 78;
    queue_random_packet();
    wait_idle();

    set_framing(8'd255, 8'd0);
    in_idle_pct   = 0;
    out_stall_pct = 78;
    queue_random_packet();
    wait_idle();

    set_framing(byte_t'($urandom), byte_t'($urandom));
    in_idle_pct   = 16;
    out_stall_pct = 16;
    queue_random_packet();
    wait_idle();

    $display("covered %0d bytes, %0d framed packets, %0d readings checked, %0d resyncs",
             bytes_done, packets_framed, readings_checked, resyncs);
    $display("start byte/index base at both extremes, defaults and random; bad index/checksum");
    if (err_count == 0)
      $display("lidar_packet_parser_tb: done, clean");
    else
      $display("lidar_packet_parser_tb: done, errors");
    $finish;
  end

endmodule
